// File: design/scs_pkg.sv
// Shared counter slot table package: field widths, request and status codes,
// FSM states and the structs broadcast to and passed along the cell row. No dependencies.
package scs_pkg;

  localparam int unsigned SEL_W    = 64;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned GEN_W    = 32;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned NSLOT_W  = 5;
  localparam int unsigned CFGIDX_W = 1;
  localparam int unsigned CFGDAT_W = 4;
  localparam int unsigned DEF_NUM_SLOTS = 8;

  typedef enum logic {
    FUNC_ACQUIRE = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_REJECT  = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [CFGIDX_W-1:0] {
    REG_PMU_PRESENT  = 1'b0,
    REG_SLOTS_IN_USE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_COMMIT = 1'b1
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic               load;
    logic               commit;
    logic               any_hit;
    logic               func;
    logic [SEL_W-1:0]   sel;
    logic [SLOT_W-1:0]  idx;
    logic               pmu;
    logic [NSLOT_W-1:0] nslots;
  } cell_cmd_t;

  // handed from cell to cell, lowest slot first
  typedef struct packed {
    logic               hit_seen;
    logic               free_seen;
    logic               done;
    logic               bump;
    logic [NSLOT_W-1:0] win_id;
  } chain_t;

endpackage

// File: design/scs_cell.sv
// One slot of the shared counter slot table: selector, reference count and
// the flags of the pending beat. Depends on scs_pkg.
module scs_cell
  import scs_pkg::*;
#(
  parameter int unsigned CELL_ID = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  chain_t    chain_in,
  output chain_t    chain_out,
  output logic      live_next
);

  localparam logic [NSLOT_W-1:0] ID = NSLOT_W'(CELL_ID);

  logic [SEL_W-1:0] selector;
  logic [CNT_W-1:0] count;
  logic             hit;
  logic             free;
  logic             rel;

  logic             live;
  logic             en;
  logic             take_hit;
  logic             take_free;
  logic             last_ref;

  assign live = (count != '0);
  assign en   = cmd.pmu && (ID < cmd.nslots);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit  <= 1'b0;
      free <= 1'b0;
      rel  <= 1'b0;
    end else if (cmd.load) begin
      hit  <= en && (cmd.func == FUNC_ACQUIRE) && (cmd.sel != '0) && live
              && (selector == cmd.sel);
      free <= en && (cmd.func == FUNC_ACQUIRE) && (cmd.sel != '0) && !live;
      rel  <= en && (cmd.func == FUNC_RELEASE) && live
              && (NSLOT_W'(cmd.idx) == ID);
    end
  end

  assign take_hit  = hit && !chain_in.hit_seen;
  assign take_free = free && !cmd.any_hit && !chain_in.free_seen;
  assign last_ref  = (count == CNT_W'(1));

  always_comb begin
    chain_out.hit_seen  = chain_in.hit_seen | hit;
    chain_out.free_seen = chain_in.free_seen | free;
    chain_out.done      = chain_in.done | take_hit | take_free | rel;
    chain_out.bump      = chain_in.bump | take_free | (rel && last_ref);
    chain_out.win_id    = (take_hit || take_free) ? ID : chain_in.win_id;
  end

  always_comb begin
    live_next = live;
    if (cmd.commit) begin
      if (take_hit || take_free) begin
        live_next = 1'b1;
      end else if (rel && last_ref) begin
        live_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selector <= '0;
      count    <= '0;
    end else if (cmd.commit) begin
      if (take_hit) begin
        if (count != '1) begin
          count <= count + CNT_W'(1);
        end
      end else if (take_free) begin
        selector <= cmd.sel;
        count    <= CNT_W'(1);
      end else if (rel) begin
        count <= count - CNT_W'(1);
        if (last_ref) begin
          selector <= '0;
        end
      end
    end
  end

endmodule

// File: design/shared_counter_slot_table_unit.sv
// Shared counter slot table: top level with request control, configuration
// registers, generation counter and the row of slot cells. Depends on scs_pkg, scs_cell.
//
// Usage: an input beat (func, event_selector, slot_index) is taken when in_valid
// is high and in_stall low. An acquire shares the lowest live slot holding the
// same selector, else claims the lowest free slot; a release drops one
// reference of slot_index. Each input beat yields exactly one output beat
// (status, slot_granted, live_mask, generation) on out_valid / out_stall.
// Timing: on accept every cell registers its per-slot match, free and release
// flags; in the commit step the winner is resolved along the cell row, the
// slot is updated and the output register is loaded. in_stall is high during
// the commit step. A new beat is accepted while a finished result still waits
// in the output register. When the receiver stalls with a result pending, the
// next item holds in its commit step until the output register frees. The
// user must write configuration (cfg_we, cfg_index, cfg_data) only while idle;
// the block does not enforce this. Reset clears all slots, the generation and
// out_valid, sets pmu_present to 1 and slots_in_use to 8.
module shared_counter_slot_table_unit
  import scs_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [SEL_W-1:0]    event_selector,
  input  logic [SLOT_W-1:0]   slot_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   status,
  output logic [SLOT_W-1:0]   slot_granted,
  output logic [MASK_W-1:0]   live_mask,
  output logic [GEN_W-1:0]    generation,
  input  logic                cfg_we,
  input  logic [CFGIDX_W-1:0] cfg_index,
  input  logic [CFGDAT_W-1:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic                pmu_present;
  logic [CFGDAT_W-1:0] slots_in_use;
  logic [NSLOT_W-1:0]  nslots;
  logic [GEN_W-1:0]    table_generation;
  logic                req_func;
  logic [SLOT_W-1:0]   req_idx;
  logic [SEL_W-1:0]    req_sel;

  logic                accept;
  logic                commit;
  cell_cmd_t           cmd;
  chain_t              chain [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] live_vec;
  logic [GEN_W-1:0]    gen_next;

  assign nslots = (NSLOT_W'(slots_in_use) > NSLOT_W'(NUM_SLOTS)) ?
                  NSLOT_W'(NUM_SLOTS) : NSLOT_W'(slots_in_use);

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pmu_present  <= 1'b1;
      slots_in_use <= CFGDAT_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PMU_PRESENT:  pmu_present  <= cfg_data[0];
        REG_SLOTS_IN_USE: slots_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func <= func;
      req_idx  <= slot_index;
      req_sel  <= event_selector;
    end
  end

  always_comb begin
    cmd.load    = accept;
    cmd.commit  = commit;
    cmd.any_hit = chain[NUM_SLOTS].hit_seen;
    cmd.func    = func;
    cmd.sel     = (state == S_IDLE) ? event_selector : req_sel;
    cmd.idx     = slot_index;
    cmd.pmu     = pmu_present;
    cmd.nslots  = nslots;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    scs_cell #(
      .CELL_ID(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .live_next (live_vec[i])
    );
  end

  assign gen_next = chain[NUM_SLOTS].bump ? table_generation + GEN_W'(1) :
                    table_generation;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_generation <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (commit) begin
        table_generation <= gen_next;
        out_valid        <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      live_mask  <= MASK_W'(live_vec);
      generation <= gen_next;
      if (req_func == FUNC_RELEASE) begin
        slot_granted <= req_idx;
        status       <= chain[NUM_SLOTS].done ? ST_DONE : ST_IGNORED;
      end else begin
        slot_granted <= chain[NUM_SLOTS].done ? SLOT_W'(chain[NUM_SLOTS].win_id) : '0;
        status       <= chain[NUM_SLOTS].done ? ST_DONE : ST_REJECT;
      end
    end
  end

endmodule

// File: tb/tb_shared_counter_slot_table_unit.sv
`timescale 1ns / 1ps
// Testbench for shared_counter_slot_table_unit: directed and random acquire and release
// beats, checked field by field against a slot table kept in a scoreboard class.
// Depends on scs_pkg and the design sources; reads no files.
module tb_shared_counter_slot_table_unit
  import scs_pkg::*;
();

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned RANDOM_PER_PHASE = 130;
  localparam int unsigned POOL_SIZE = 6;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [MASK_W-1:0] mask;
    logic [GEN_W-1:0]  gen;
  } slot_result_t;

  class slot_table_scoreboard;
    logic [SEL_W-1:0]    slot_sel[DEF_NUM_SLOTS];
    logic [CNT_W-1:0]    slot_refs[DEF_NUM_SLOTS];
    logic [GEN_W-1:0]    gen_count;
    logic                enabled;
    logic [CFGDAT_W-1:0] slot_limit;
    slot_result_t        expected_q[$];
    int                  errors;

    function new();
      foreach (slot_sel[i]) begin
        slot_sel[i] = '0;
        slot_refs[i] = '0;
      end
      gen_count = '0;
      enabled = 1'b1;
      slot_limit = CFGDAT_W'(8);
      errors = 0;
    endfunction

    function void set_config(cfg_reg_t r, logic [CFGDAT_W-1:0] d);
      if (r == REG_PMU_PRESENT) begin
        enabled = d[0];
      end else begin
        slot_limit = d;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int pick_live();
      int live[$];
      foreach (slot_refs[i]) if (slot_refs[i] != '0) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function void note_request(func_t f, logic [SEL_W-1:0] sel, logic [SLOT_W-1:0] idx);
      slot_result_t r;
      int n;
      bit found;
      n = (slot_limit > DEF_NUM_SLOTS) ? DEF_NUM_SLOTS : int'(slot_limit);
      found = 1'b0;
      r.slot = '0;
      if (f == FUNC_ACQUIRE) begin
        r.status = ST_REJECT;
        if (enabled && sel != '0) begin
          // share the lowest live match first, else claim the lowest free slot
          for (int i = 0; i < n; i++) begin
            if (!found && slot_refs[i] != '0 && slot_sel[i] == sel) begin
              if (slot_refs[i] != '1) slot_refs[i] = slot_refs[i] + 1'b1;
              r.slot = SLOT_W'(i);
              found = 1'b1;
            end
          end
          for (int i = 0; i < n; i++) begin
            if (!found && slot_refs[i] == '0) begin
              slot_sel[i] = sel;
              slot_refs[i] = CNT_W'(1);
              gen_count = gen_count + 1'b1;
              r.slot = SLOT_W'(i);
              found = 1'b1;
            end
          end
          if (found) r.status = ST_DONE;
        end
      end else begin
        r.status = ST_IGNORED;
        r.slot = idx;
        if (enabled && idx < n && slot_refs[idx] != '0) begin
          slot_refs[idx] = slot_refs[idx] - 1'b1;
          if (slot_refs[idx] == '0) begin
            slot_sel[idx] = '0;
            gen_count = gen_count + 1'b1;
          end
          r.status = ST_DONE;
        end
      end
      r.mask = '0;
      foreach (slot_refs[i]) r.mask[i] = (slot_refs[i] != '0);
      r.gen = gen_count;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] slot,
                      logic [MASK_W-1:0] mask, logic [GEN_W-1:0] gen);
      slot_result_t w;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        w = expected_q.pop_front();
        if (st !== w.status) report($sformatf("status got %0h, expected %0h", st, w.status));
        if (slot !== w.slot) report($sformatf("slot_granted got %0h, expected %0h", slot, w.slot));
        if (mask !== w.mask) report($sformatf("live_mask got %0h, expected %0h", mask, w.mask));
        if (gen !== w.gen) report($sformatf("generation got %0h, expected %0h", gen, w.gen));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                func = 1'b0;
  logic [SEL_W-1:0]    event_selector = '0;
  logic [SLOT_W-1:0]   slot_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [SLOT_W-1:0]   slot_granted;
  logic [MASK_W-1:0]   live_mask;
  logic [GEN_W-1:0]    generation;
  logic                cfg_we = 1'b0;
  logic [CFGIDX_W-1:0] cfg_index = '0;
  logic [CFGDAT_W-1:0] cfg_data = '0;

  slot_table_scoreboard sb;
  bit                   no_gaps = 1'b0;
  logic [SEL_W-1:0]     sel_pool[POOL_SIZE];
  int unsigned          idle_cycles;

  shared_counter_slot_table_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .event_selector (event_selector),
    .slot_index     (slot_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .slot_granted   (slot_granted),
    .live_mask      (live_mask),
    .generation     (generation),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_wait();
    if (no_gaps) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic send(func_t f, logic [SEL_W-1:0] sel, logic [SLOT_W-1:0] idx);
    int gap;
    gap = pick_wait();
    if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    event_selector <= sel;
    slot_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_request(f, sel, idx);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_config(logic pmu, logic [CFGDAT_W-1:0] slots);
    logic [CFGDAT_W-1:0] pmu_word;
    pmu_word = {3'($urandom_range(0, 7)), pmu};
    cfg_we <= 1'b1;
    cfg_index <= REG_PMU_PRESENT;
    cfg_data <= pmu_word;
    @(posedge clk);
    sb.set_config(REG_PMU_PRESENT, pmu_word);
    cfg_index <= REG_SLOTS_IN_USE;
    cfg_data <= slots;
    @(posedge clk);
    sb.set_config(REG_SLOTS_IN_USE, slots);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int r;
    int live;
    func_t f;
    logic [SEL_W-1:0] sel;
    logic [SLOT_W-1:0] idx;
    r = $urandom_range(0, 99);
    idx = SLOT_W'($urandom_range(0, 7));
    sel = {$urandom, $urandom};
    f = FUNC_ACQUIRE;
    if (r < 45) begin
      sel = sel_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (r >= 53 && r < 56) begin
      sel = '0;
    end else if (r >= 56) begin
      f = FUNC_RELEASE;
      live = sb.pick_live();
      if (live >= 0 && $urandom_range(0, 3) != 0) idx = SLOT_W'(live);
    end
    send(f, sel, idx);
  endtask

  task automatic run_phase(logic pmu, logic [CFGDAT_W-1:0] slots, bit hold_mid);
    drain_results();
    repeat (2) @(posedge clk);
    write_config(pmu, slots);
    foreach (sel_pool[i]) sel_pool[i] = {$urandom, $urandom};
    for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
      // hold the sender until the table has answered everything
      if ((hold_mid && k == RANDOM_PER_PHASE / 2) || $urandom_range(0, 149) == 0)
        drain_results();
      random_request();
    end
  endtask

  initial begin
    int w;
    forever begin
      w = pick_wait();
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (rst || out_valid !== 1'b1);
      sb.check_result(status, slot_granted, live_mask, generation);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[shared_counter_slot_table_unit] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_config(1'b1, CFGDAT_W'(8));

    send(FUNC_ACQUIRE, '0, SLOT_W'(0));
    send(FUNC_ACQUIRE, '1, '1);
    send(FUNC_ACQUIRE, '1, SLOT_W'(0));
    for (int k = 0; k < 7; k++) send(FUNC_ACQUIRE, 64'd1 << k, SLOT_W'(k));
    send(FUNC_ACQUIRE, 64'h8000_0000_0000_0000, '1);
    send(FUNC_RELEASE, '1, SLOT_W'(7));
    send(FUNC_RELEASE, '0, SLOT_W'(7));
    send(FUNC_RELEASE, '1, SLOT_W'(0));
    send(FUNC_RELEASE, '0, SLOT_W'(0));
    send(FUNC_ACQUIRE, 64'h8000_0000_0000_0000, SLOT_W'(0));

    run_phase(1'b1, CFGDAT_W'(8), 1'b1);
    run_phase(1'b1, CFGDAT_W'(3), 1'b0);
    run_phase(1'b0, CFGDAT_W'(8), 1'b0);
    run_phase(1'b1, CFGDAT_W'(1), 1'b0);
    run_phase(1'b1, CFGDAT_W'(0), 1'b0);
    run_phase(1'b1, CFGDAT_W'(15), 1'b0);
    run_phase(1'b0, CFGDAT_W'(0), 1'b0);
    run_phase(1'b1, CFGDAT_W'(5), 1'b0);
    run_phase(1'b1, CFGDAT_W'(12), 1'b0);
    run_phase(1'b1, CFGDAT_W'(8), 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[shared_counter_slot_table_unit] OK");
    end else begin
      $display("[shared_counter_slot_table_unit] ERROR");
    end
    $finish;
  end

endmodule
